// ----- hdl/sspp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_pkg - servo status packet parser shared definitions
// Packet phases, queue entry layout and status codes used by the front end,
// the command queue and the result formatter.
// ----------------------------------------------------------------------------
package sspp_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    // Reset value of the max_length register
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd16;

    // Error byte and checksum are counted in the length byte
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN    = 3'd3,
        PH_ERR    = 3'd4,
        PH_PARAM  = 3'd5,
        PH_CHK    = 3'd6
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_LEN_BIG   = 3'd1,
        ST_CHECKSUM  = 3'd2,
        ST_ID        = 3'd3,
        ST_SERVO_ERR = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_PARAM = 2'd0,
        OP_ABORT = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One classified item handed from the front end to the formatter
    typedef struct packed {
        op_t              op;
        logic [BYTE_W-1:0] idx;        // parameter position
        logic [BYTE_W-1:0] value;      // parameter byte or received checksum
        logic [BYTE_W-1:0] calc_sum;   // inverted running sum
        logic [BYTE_W-1:0] resp_id;
        logic [BYTE_W-1:0] exp_id;
        logic [BYTE_W-1:0] servo_err;
    } cmd_t;

endpackage : sspp_pkg
`default_nettype wire

// ----- hdl/sspp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_front - packet walker
// Accepts received bytes, tracks the packet phase, accumulates the checksum
// and pushes one classified entry per byte that yields a result.
// ----------------------------------------------------------------------------
module sspp_front
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      acc,
    input  wire                      start_req,
    input  wire  [7:0]               rx_byte,
    input  wire  [7:0]               expected_id,
    input  wire  [7:0]               max_length,
    output logic                     push,
    output sspp_pkg::cmd_t           cmd
);
    import sspp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] id_reg,   id_next;
    logic [BYTE_W-1:0] len_reg,  len_next;
    logic [BYTE_W-1:0] err_reg,  err_next;
    logic [BYTE_W-1:0] sum_reg,  sum_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] idx_reg,  idx_next;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] param_cnt;
    logic              len_big;

    assign sum_add   = sum_reg + rx_byte;
    assign param_cnt = (len_reg >= LEN_OVERHEAD) ? (len_reg - LEN_OVERHEAD) : '0;
    assign len_big   = (rx_byte > max_length);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        if (acc)
        begin
            if (start_req)
            begin
                phase_next = PH_HEADER;
                id_next    = '0;
                len_next   = '0;
                err_next   = '0;
                sum_next   = '0;
                left_next  = '0;
                idx_next   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER: phase_next = PH_ID;
                    PH_ID:
                    begin
                        id_next    = rx_byte;
                        sum_next   = rx_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next   = rx_byte;
                        sum_next   = sum_add;
                        phase_next = len_big ? PH_IDLE : PH_ERR;
                    end
                    PH_ERR:
                    begin
                        err_next   = rx_byte;
                        sum_next   = sum_add;
                        left_next  = param_cnt;
                        idx_next   = '0;
                        phase_next = (param_cnt != '0) ? PH_PARAM : PH_CHK;
                    end
                    PH_PARAM:
                    begin
                        sum_next   = sum_add;
                        left_next  = left_reg - 8'd1;
                        idx_next   = idx_reg + 8'd1;
                        if (left_reg == 8'd1)
                            phase_next = PH_CHK;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Outputs
    always_comb
    begin
        push          = 1'b0;
        cmd.op        = OP_PARAM;
        cmd.idx       = idx_reg;
        cmd.value     = rx_byte;
        cmd.calc_sum  = ~sum_reg;
        cmd.resp_id   = id_reg;
        cmd.exp_id    = expected_id;
        cmd.servo_err = err_reg;
        if (acc && !start_req)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    push   = len_big;
                    cmd.op = OP_ABORT;
                end
                PH_PARAM:
                begin
                    push   = 1'b1;
                    cmd.op = OP_PARAM;
                end
                PH_CHK:
                begin
                    push   = 1'b1;
                    cmd.op = OP_CHECK;
                end
                default: push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            id_reg    <= '0;
            len_reg   <= '0;
            err_reg   <= '0;
            sum_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            sum_reg   <= sum_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
        end
    end

endmodule : sspp_front
`default_nettype wire

// ----- hdl/sspp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_queue - command queue
// Small first-in first-out store between the packet walker and the result
// formatter so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sspp_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  sspp_pkg::cmd_t           push_data,
    output logic                     full,
    input  wire                      pop,
    output logic                     not_empty,
    output sspp_pkg::cmd_t           pop_data
);
    import sspp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule : sspp_queue
`default_nettype wire

// ----- hdl/sspp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_back - result formatter
// Takes queued entries, settles the final status by check priority and holds
// the result in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module sspp_back
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      q_valid,
    input  sspp_pkg::cmd_t           q_data,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [39:0]              m_tdata,
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);
    import sspp_pkg::*;

    logic                valid_reg;
    logic                kind_reg,   kind_next;
    logic [BYTE_W-1:0]   idx_reg,    idx_next;
    logic [BYTE_W-1:0]   val_reg,    val_next;
    status_t             status_reg, status_next;
    logic [BYTE_W-1:0]   err_reg,    err_next;
    logic [BYTE_W-1:0]   id_reg,     id_next;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb
    begin
        kind_next   = KIND_PARAM;
        idx_next    = q_data.idx;
        val_next    = q_data.value;
        status_next = ST_OK;
        err_next    = q_data.servo_err;
        id_next     = q_data.resp_id;
        unique case (q_data.op)
            OP_PARAM: kind_next = KIND_PARAM;
            OP_ABORT:
            begin
                kind_next   = KIND_STATUS;
                idx_next    = '0;
                val_next    = '0;
                err_next    = '0;
                status_next = ST_LEN_BIG;
            end
            OP_CHECK:
            begin
                kind_next = KIND_STATUS;
                idx_next  = '0;
                val_next  = '0;
                priority if (q_data.calc_sum != q_data.value)
                    status_next = ST_CHECKSUM;
                else if (q_data.resp_id != q_data.exp_id)
                    status_next = ST_ID;
                else if (q_data.servo_err != '0)
                    status_next = ST_SERVO_ERR;
                else
                    status_next = ST_OK;
            end
            default: kind_next = KIND_PARAM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // Payload holds while the sink stalls
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
            val_reg    <= val_next;
            status_reg <= status_next;
            err_reg    <= err_next;
            id_reg     <= id_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = kind_reg;
    assign m_tdata  = {5'd0, id_reg, err_reg, status_reg, val_reg, idx_reg};

endmodule : sspp_back
`default_nettype wire

// ----- hdl/servo_status_packet_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// servo_status_packet_parser - servo status packet parser top level
// Walks received status packet bytes, emits parameter bytes and a final
// status with length, checksum, id and servo error checks.
//
//  Port group  Dir   Payload
//  s_*         in    tdata: rx_byte, expected_id; tuser: start_req
//  m_*         out   tdata: param_index, param_value, status, servo_error,
//                    response_id; tuser: kind; tlast: last
//  p*          APB   register 0 at address 0: max_length (reset 16)
//
//  One byte is taken per cycle while the command queue is not full; a result
//  reaches m_* by way of the command queue and then the output register.
//  The walker stalls only when the command queue is full; the queue depth
//  sets how many results may back up behind a stalled sink.
//  Reset returns the walker to idle and empties the queue.
// ----------------------------------------------------------------------------
module servo_status_packet_parser
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [15:0]  s_tdata,   // [7:0] rx_byte, [15:8] expected_id
    input  wire  [0:0]   s_tuser,   // [0] start_req
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [39:0]  m_tdata,   // [7:0] param_index, [15:8] param_value,
                                    // [18:16] status, [26:19] servo_error,
                                    // [34:27] response_id, [39:35] zero
    output logic [0:0]   m_tuser,   // [0] kind
    output logic         m_tlast,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sspp_pkg::*;

    logic              acc;
    logic              push;
    cmd_t              push_cmd;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    cmd_t              q_cmd;
    logic [BYTE_W-1:0] max_len_reg;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {24'd0, max_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LENGTH_RESET;
        else if (cfg_wr)
            max_len_reg <= pwdata[7:0];
    end

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    sspp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .start_req   (s_tuser[0]),
        .rx_byte     (s_tdata[7:0]),
        .expected_id (s_tdata[15:8]),
        .max_length  (max_len_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    sspp_queue #(.DEPTH(FIFO_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_cmd)
    );

    sspp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule : servo_status_packet_parser
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - servo_status_packet_parser testbench
// A byte stream of status packets is driven into the parser at random pace,
// and every output transfer is checked against a bit-level prediction of the
// packet walk. A short directed table comes first. Random packets follow at
// several max_length settings, mostly well formed, some cut short or
// followed by stray bytes. Both sides stall at random, with one quiet phase.
// ----------------------------------------------------------------------------
module tb;

    import sspp_pkg::*;

    localparam logic [2:0] ADDR_MAX_LENGTH = 3'd0;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         PHASE_BYTES     = 200;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] value;
        status_t           status;
        logic [BYTE_W-1:0] err;
        logic [BYTE_W-1:0] id;
        logic              last;
    } parse_result_t;

    typedef struct {
        logic              start;
        logic [BYTE_W-1:0] rx;
        logic [BYTE_W-1:0] eid;
        bit                typed;
        status_t           st;
        logic [BYTE_W-1:0] err;
        logic [BYTE_W-1:0] id;
    } byte_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;   // [7:0] rx_byte, [15:8] expected_id
    logic [0:0]   s_tuser;   // [0] start_req
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;   // [7:0] param_index, [15:8] param_value, [18:16] status,
                             // [26:19] servo_error, [34:27] response_id, [39:35] zero
    logic [0:0]   m_tuser;   // [0] kind
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    servo_status_packet_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted parser state
    phase_t            walk_phase;
    logic [BYTE_W-1:0] walk_id;
    logic [BYTE_W-1:0] walk_len;
    logic [BYTE_W-1:0] walk_err;
    logic [BYTE_W-1:0] walk_sum;
    logic [BYTE_W-1:0] walk_left;
    logic [BYTE_W-1:0] max_len_q;

    parse_result_t awaited_results[$];
    int            mismatches;
    bit            no_idle;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("** servo_status_packet_parser: FAILED **");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] param_total();
        return (walk_len >= LEN_OVERHEAD) ? walk_len - LEN_OVERHEAD : '0;
    endfunction

    // Advance the predicted walk by one byte; returns 1 when a result is due.
    function automatic bit parse_rx_byte(input logic start, input logic [BYTE_W-1:0] b,
                                         input logic [BYTE_W-1:0] eid,
                                         output parse_result_t res);
        res = '0;
        if (start)
        begin
            walk_phase = PH_HEADER;
            walk_id    = '0;
            walk_len   = '0;
            walk_err   = '0;
            walk_sum   = '0;
            walk_left  = '0;
            return 1'b0;
        end
        case (walk_phase)
            PH_HEADER:
            begin
                walk_phase = PH_ID;
                return 1'b0;
            end
            PH_ID:
            begin
                walk_id    = b;
                walk_sum   = b;
                walk_phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN:
            begin
                walk_len = b;
                walk_sum = walk_sum + b;
                if (b > max_len_q)
                begin
                    walk_phase = PH_IDLE;
                    res.kind   = KIND_STATUS;
                    res.status = ST_LEN_BIG;
                    res.id     = walk_id;
                    res.last   = 1'b1;
                    return 1'b1;
                end
                walk_phase = PH_ERR;
                return 1'b0;
            end
            PH_ERR:
            begin
                walk_err   = b;
                walk_sum   = walk_sum + b;
                walk_left  = param_total();
                walk_phase = (walk_left != 0) ? PH_PARAM : PH_CHK;
                return 1'b0;
            end
            PH_PARAM:
            begin
                res.kind  = KIND_PARAM;
                res.idx   = param_total() - walk_left;
                res.value = b;
                res.status = ST_OK;
                res.err   = walk_err;
                res.id    = walk_id;
                walk_sum  = walk_sum + b;
                walk_left = walk_left - 8'd1;
                if (walk_left == 0)
                    walk_phase = PH_CHK;
                return 1'b1;
            end
            PH_CHK:
            begin
                res.kind = KIND_STATUS;
                if (~walk_sum != b)
                    res.status = ST_CHECKSUM;
                else if (walk_id != eid)
                    res.status = ST_ID;
                else if (walk_err != 0)
                    res.status = ST_SERVO_ERR;
                else
                    res.status = ST_OK;
                res.err    = walk_err;
                res.id     = walk_id;
                res.last   = 1'b1;
                walk_phase = PH_IDLE;
                return 1'b1;
            end
            default:
            begin
                walk_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("output transfer with no result awaited: tdata %0h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
                check_field("param_index", 32'(want.idx), 32'(m_tdata[7:0]));
                check_field("param_value", 32'(want.value), 32'(m_tdata[15:8]));
                check_field("status", 32'(want.status), 32'(m_tdata[18:16]));
                check_field("servo_error", 32'(want.err), 32'(m_tdata[26:19]));
                check_field("response_id", 32'(want.id), 32'(m_tdata[34:27]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it; returns at the accepting edge.
    task automatic send_byte(input logic start, input logic [BYTE_W-1:0] rx,
                             input logic [BYTE_W-1:0] eid, input bit typed,
                             input parse_result_t typed_res);
        parse_result_t res;
        bit            due;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {eid, rx};
        do
            @(posedge clk);
        while (!s_tready);
        due = parse_rx_byte(start, rx, eid, res);
        if (typed)
            awaited_results.push_back(typed_res);
        else if (due)
            awaited_results.push_back(res);
    endtask

    // Hold the sender until every awaited result has been taken.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_max_length();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_MAX_LENGTH, '0, rd);
        check_field("max_length", {24'b0, max_len_q}, rd);
    endtask

    task automatic write_max_length(input logic [BYTE_W-1:0] v);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_MAX_LENGTH, {24'b0, v}, rd);
        max_len_q = v;
        read_max_length();
    endtask

    // One random packet; returns the number of packet bytes sent.
    task automatic send_packet(output int sent);
        logic [BYTE_W-1:0] eid;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] err;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] pkt[$];
        int                cap;
        int                r;
        int                cut;
        eid = 8'($urandom_range(0, 255));
        id  = ($urandom_range(0, 99) < 80) ? eid : 8'($urandom_range(0, 255));
        cap = (max_len_q < 8'd12) ? int'(max_len_q) : 12;
        r   = $urandom_range(0, 99);
        if (r < 2)
            len = max_len_q;
        else if (r < 9 && max_len_q != 8'hFF)
            len = 8'($urandom_range(max_len_q + 1, 255));
        else if (r < 15)
            len = 8'($urandom_range(0, 1));
        else
            len = 8'($urandom_range(0, cap));
        err = ($urandom_range(0, 99) < 70) ? 8'h00 : 8'($urandom_range(1, 255));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(id);
        pkt.push_back(len);
        if (len <= max_len_q)
        begin
            pkt.push_back(err);
            sum = id + len + err;
            for (int i = 2; i < len; i++)
            begin
                b = 8'($urandom_range(0, 255));
                sum += b;
                pkt.push_back(b);
            end
            pkt.push_back(($urandom_range(0, 99) < 85) ? ~sum : 8'($urandom_range(0, 255)));
        end
        // cut some packets short, so that the next start lands mid-packet
        cut  = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 5) : pkt.size();
        sent = 0;
        foreach (pkt[i])
        begin
            if (i >= cut)
                break;
            send_byte(i == 0, pkt[i], eid, 1'b0, '0);
            sent++;
        end
        // stray bytes between packets
        if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(1, 3))
                send_byte(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'b0, '0);
    endtask

    byte_row_t byte_table[] = '{
        // well-formed packet, one parameter: ok
        '{1'b1, 8'hFF, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h01, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h03, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h20, 8'h01, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'hDB, 8'h01, 1'b1, ST_OK, 8'h00, 8'h01},
        // length one above the reset limit: abort right after the length byte
        '{1'b1, 8'h00, 8'h05, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h05, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h05, 8'h05, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h11, 8'h05, 1'b1, ST_LEN_BIG, 8'h00, 8'h05},
        // byte while idle: dropped
        '{1'b0, 8'h00, 8'h00, 1'b0, ST_OK, 8'h00, 8'h00},
        // zero length, checksum straight after the error byte: servo error
        '{1'b1, 8'h00, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h80, 8'hFF, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h80, 8'hFF, 1'b1, ST_SERVO_ERR, 8'h80, 8'hFF},
        // restart inside the header, then id mismatch
        '{1'b1, 8'h00, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b1, 8'hFF, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h02, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h02, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'h03, 1'b0, ST_OK, 8'h00, 8'h00},
        '{1'b0, 8'hFB, 8'h03, 1'b1, ST_ID, 8'h00, 8'h02}
    };

    logic [BYTE_W-1:0] limit_steps[] = '{8'hFF, 8'h00, 8'h01, 8'h02, 8'h10, 8'h00, 8'h00};

    initial
    begin
        parse_result_t typed_res;
        int            phase_bytes;
        int            sent;
        int            packets;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        no_idle    = 1'b0;
        max_len_q  = MAX_LENGTH_RESET;
        walk_phase = PH_IDLE;
        walk_id    = '0;
        walk_len   = '0;
        walk_err   = '0;
        walk_sum   = '0;
        walk_left  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        read_max_length();
        foreach (byte_table[i])
        begin
            typed_res = '{kind: KIND_STATUS, idx: '0, value: '0, status: byte_table[i].st,
                          err: byte_table[i].err, id: byte_table[i].id, last: 1'b1};
            send_byte(byte_table[i].start, byte_table[i].rx, byte_table[i].eid,
                      byte_table[i].typed, typed_res);
        end
        drain_results();

        foreach (limit_steps[p])
        begin
            if (p >= 5)
                write_max_length(8'($urandom_range(0, 255)));
            else
                write_max_length(limit_steps[p]);
            no_idle     = (p == 3);
            phase_bytes = 0;
            packets     = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                send_packet(sent);
                phase_bytes += sent;
                packets++;
                // pause the sender now and then until the output side catches up
                if (packets % 40 == 0)
                    drain_results();
            end
            drain_results();
        end
        no_idle = 1'b0;

        if (mismatches == 0)
            $display("** servo_status_packet_parser: PASSED **");
        else
            $display("** servo_status_packet_parser: FAILED **");
        $finish;
    end

endmodule
